// ===== rtl/dqtd_pkg.sv =====
// ============================================================================
// dqtd_pkg
// Shared types and constants for the dq to three-phase duty pipeline.
// ============================================================================
package dqtd_pkg;

    // CORDIC datapath
    localparam int CORDIC_STAGES = 30;
    localparam int XY_W          = 34;   // Q2.30 plus guard bits
    localparam int Z_W           = 33;   // residual angle, full turn = 2^32

    // Stage counts of the blocks behind the CORDIC
    localparam int TRANSFORM_STAGES = 6;
    localparam int DUTY_STAGES      = 3;
    localparam int PIPE_STAGES      = 1 + CORDIC_STAGES + TRANSFORM_STAGES + DUTY_STAGES;

    // Start gain of the rotation (1/K in Q2.30)
    localparam logic signed [XY_W-1:0] CORDIC_GAIN    = 34'sd652032874;
    // sqrt(3)/2 in Q1.30
    localparam logic signed [31:0]     SQRT3_HALF_Q30 = 32'sd929887697;

    // Configuration register indexes
    localparam logic [0:0] REG_DUTY_MIN = 1'b0;
    localparam logic [0:0] REG_DUTY_MAX = 1'b1;

    typedef logic signed [Z_W-1:0] angle_t;

    // atan(2^-i) as a fraction of one turn, 2^32 per turn
    localparam angle_t ATAN_TURN [CORDIC_STAGES] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81,
        33'sd41,        33'sd20,        33'sd10,        33'sd5,
        33'sd3,         33'sd1
    };

    // One item as it moves through the CORDIC stages
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        angle_t                 z;
        logic [1:0]             quad;
        logic signed [15:0]     volt_d;
        logic signed [15:0]     volt_q;
        logic [15:0]            inv;
    } cordic_t;

endpackage

// ===== rtl/dqtd_cordic_stage.sv =====
// ============================================================================
// dqtd_cordic_stage
// One registered micro-rotation of the sine/cosine CORDIC.
// ============================================================================
module dqtd_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               load,
    input  dqtd_pkg::cordic_t  feed,
    output dqtd_pkg::cordic_t  rotated
);

    dqtd_pkg::cordic_t stage_next;
    dqtd_pkg::cordic_t stage_reg;

    logic signed [dqtd_pkg::XY_W-1:0] x_shift;
    logic signed [dqtd_pkg::XY_W-1:0] y_shift;

    // rotate toward zero residual angle, floor shifts
    always_comb
    begin
        x_shift    = $signed(feed.x) >>> STAGE;
        y_shift    = $signed(feed.y) >>> STAGE;
        stage_next = feed;
        if (!feed.z[dqtd_pkg::Z_W-1])
        begin
            stage_next.x = $signed(feed.x) - y_shift;
            stage_next.y = $signed(feed.y) + x_shift;
            stage_next.z = $signed(feed.z) - dqtd_pkg::ATAN_TURN[STAGE];
        end
        else
        begin
            stage_next.x = $signed(feed.x) + y_shift;
            stage_next.y = $signed(feed.y) - x_shift;
            stage_next.z = $signed(feed.z) + dqtd_pkg::ATAN_TURN[STAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign rotated = stage_reg;

endmodule

// ===== rtl/dqtd_transform.sv =====
// ============================================================================
// dqtd_transform
// Quadrant fold, inverse Park and inverse Clarke, six register stages.
// ============================================================================
module dqtd_transform (
    input  logic                                     clk,
    input  logic [dqtd_pkg::TRANSFORM_STAGES-1:0]    load,
    input  dqtd_pkg::cordic_t                        rotated,
    output logic signed [32:0]                       volt_a,
    output logic signed [32:0]                       volt_b,
    output logic signed [32:0]                       volt_c,
    output logic [15:0]                              inv
);

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // round half up to Q1.15 and bound to +-1.0
    function automatic logic signed [16:0] round_unit(input logic signed [dqtd_pkg::XY_W-1:0] v);
        logic signed [dqtd_pkg::XY_W:0] r;
        logic signed [dqtd_pkg::XY_W:0] q;
        r = (dqtd_pkg::XY_W+1)'(v) + (dqtd_pkg::XY_W+1)'(16384);
        q = r >>> 15;
        if (q > 32768)
        begin
            return 17'sd32768;
        end
        else if (q < -32768)
        begin
            return -17'sd32768;
        end
        return q[16:0];
    endfunction

    // stage 0: unfold quadrant, round sine and cosine
    logic signed [dqtd_pkg::XY_W-1:0] cos_full;
    logic signed [dqtd_pkg::XY_W-1:0] sin_full;
    logic signed [16:0] cos_reg;
    logic signed [16:0] sin_reg;
    logic signed [15:0] vd0_reg;
    logic signed [15:0] vq0_reg;
    logic [15:0]        inv0_reg;

    always_comb
    begin
        case (rotated.quad)
            QUAD_I:
            begin
                cos_full = rotated.x;
                sin_full = rotated.y;
            end
            QUAD_II:
            begin
                cos_full = -$signed(rotated.y);
                sin_full = rotated.x;
            end
            QUAD_III:
            begin
                cos_full = -$signed(rotated.x);
                sin_full = -$signed(rotated.y);
            end
            QUAD_IV:
            begin
                cos_full = rotated.y;
                sin_full = -$signed(rotated.x);
            end
            default:
            begin
                cos_full = rotated.x;
                sin_full = rotated.y;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            cos_reg  <= round_unit(cos_full);
            sin_reg  <= round_unit(sin_full);
            vd0_reg  <= rotated.volt_d;
            vq0_reg  <= rotated.volt_q;
            inv0_reg <= rotated.inv;
        end
    end

    // stage 1: rotation products
    logic signed [32:0] p_dc_reg;
    logic signed [32:0] p_qs_reg;
    logic signed [32:0] p_ds_reg;
    logic signed [32:0] p_qc_reg;
    logic [15:0]        inv1_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            p_dc_reg <= vd0_reg * cos_reg;
            p_qs_reg <= vq0_reg * sin_reg;
            p_ds_reg <= vd0_reg * sin_reg;
            p_qc_reg <= vq0_reg * cos_reg;
            inv1_reg <= inv0_reg;
        end
    end

    // stage 2: alpha and beta; magnitude stays below 2^31
    logic signed [33:0] alpha_next;
    logic signed [33:0] beta_next;
    logic signed [31:0] alpha_reg;
    logic signed [31:0] beta_reg;
    logic [15:0]        inv2_reg;

    always_comb
    begin
        alpha_next = 34'(p_dc_reg) - 34'(p_qs_reg);
        beta_next  = 34'(p_ds_reg) + 34'(p_qc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            alpha_reg <= alpha_next[31:0];
            beta_reg  <= beta_next[31:0];
            inv2_reg  <= inv1_reg;
        end
    end

    // stage 3: beta times sqrt(3)/2
    logic signed [63:0] beta_k_reg;
    logic signed [31:0] alpha3_reg;
    logic [15:0]        inv3_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            beta_k_reg <= beta_reg * dqtd_pkg::SQRT3_HALF_Q30;
            alpha3_reg <= alpha_reg;
            inv3_reg   <= inv2_reg;
        end
    end

    // stage 4: phase b, rounded half up back to 2^-23 V
    logic signed [65:0] vb_sum;
    logic signed [65:0] vb_shift;
    logic signed [32:0] va4_reg;
    logic signed [32:0] vb4_reg;
    logic [15:0]        inv4_reg;

    always_comb
    begin
        vb_sum   = 66'(beta_k_reg) - (66'(alpha3_reg) <<< 29) + 66'sd536870912;
        vb_shift = vb_sum >>> 30;
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            va4_reg  <= 33'(alpha3_reg);
            vb4_reg  <= vb_shift[32:0];
            inv4_reg <= inv3_reg;
        end
    end

    // stage 5: phase c = -a - b
    logic signed [33:0] vc_next;
    logic signed [32:0] va5_reg;
    logic signed [32:0] vb5_reg;
    logic signed [32:0] vc5_reg;
    logic [15:0]        inv5_reg;

    assign vc_next = -34'(va4_reg) - 34'(vb4_reg);

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            va5_reg  <= va4_reg;
            vb5_reg  <= vb4_reg;
            vc5_reg  <= vc_next[32:0];
            inv5_reg <= inv4_reg;
        end
    end

    assign volt_a = va5_reg;
    assign volt_b = vb5_reg;
    assign volt_c = vc5_reg;
    assign inv    = inv5_reg;

endmodule

// ===== rtl/dqtd_duty.sv =====
// ============================================================================
// dqtd_duty
// Scales phase voltages by 1/Vdc, centers at one half and clips to limits.
// ============================================================================
module dqtd_duty (
    input  logic                                 clk,
    input  logic [dqtd_pkg::DUTY_STAGES-1:0]     load,
    input  logic signed [32:0]                   volt_a,
    input  logic signed [32:0]                   volt_b,
    input  logic signed [32:0]                   volt_c,
    input  logic [15:0]                          inv,
    input  logic [15:0]                          duty_min,
    input  logic [15:0]                          duty_max,
    output logic [15:0]                          duty_a,
    output logic [15:0]                          duty_b,
    output logic [15:0]                          duty_c
);

    localparam int PHASES = 3;

    logic signed [32:0] volt [PHASES];
    logic signed [49:0] prod_reg [PHASES];
    logic signed [24:0] center_reg [PHASES];
    logic [15:0]        duty_reg [PHASES];

    assign volt[0] = volt_a;
    assign volt[1] = volt_b;
    assign volt[2] = volt_c;

    for (genvar p = 0; p < PHASES; p++)
    begin : g_phase
        logic signed [49:0] rnd;
        logic signed [49:0] rnd_shift;
        logic signed [24:0] center_next;
        logic signed [24:0] clip_hi;
        logic signed [24:0] clip_lo;

        // stage 0: scale by inverse link voltage, units of 2^-43
        always_ff @(posedge clk)
        begin
            if (load[0])
            begin
                prod_reg[p] <= volt[p] * $signed({1'b0, inv});
            end
        end

        // stage 1: round half up to Q0.16 and add one half
        always_comb
        begin
            rnd         = prod_reg[p] + 50'sd67108864;
            rnd_shift   = rnd >>> 27;
            center_next = 25'(rnd_shift) + 25'sd32768;
        end

        always_ff @(posedge clk)
        begin
            if (load[1])
            begin
                center_reg[p] <= center_next;
            end
        end

        // stage 2: upper limit first, then lower limit
        always_comb
        begin
            clip_hi = center_reg[p];
            if (clip_hi > $signed({9'b0, duty_max}))
            begin
                clip_hi = $signed({9'b0, duty_max});
            end
            clip_lo = clip_hi;
            if (clip_lo < $signed({9'b0, duty_min}))
            begin
                clip_lo = $signed({9'b0, duty_min});
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[2])
            begin
                duty_reg[p] <= clip_lo[15:0];
            end
        end
    end

    assign duty_a = duty_reg[0];
    assign duty_b = duty_reg[1];
    assign duty_c = duty_reg[2];

endmodule

// ===== rtl/dq_to_three_phase_duty_core.sv =====
// ============================================================================
// dq_to_three_phase_duty_core
// Inverse Park / inverse Clarke transform with sinusoidal PWM duty output.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries a d/q voltage command, the
//   electrical angle and 1/Vdc. Output channel (out_valid/out_ready) carries
//   the three clipped phase duties. One result per input transfer.
//   Config port: cfg_we writes cfg_data into duty_min or duty_max as chosen
//   by cfg_index; write only while no item is in flight.
// Timing:
//   Fully pipelined, 40 register stages: 1 angle quantizer, 30 CORDIC
//   micro-rotations, 6 transform stages, 3 duty stages. One item per
//   cycle is sustained while out_ready stays high.
// Stall:
//   Each stage holds its item while the next one is full and stalled;
//   empty stages keep filling, so in_ready drops only once every stage
//   holds an item and out_ready is low.
// Reset:
//   rst_n clears all stage valid bits and loads duty_min = 0,
//   duty_max = 65535.
// ============================================================================
module dq_to_three_phase_duty_core #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] volt_d,
    input  logic signed [15:0] volt_q,
    input  logic signed [15:0] elec_angle,
    input  logic [15:0]        inv_link_voltage,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        duty_a,
    output logic [15:0]        duty_b,
    output logic [15:0]        duty_c,

    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int NSTG        = dqtd_pkg::PIPE_STAGES;
    localparam int PHASE_SHIFT = 32 - SINE_TABLE_BITS;
    localparam int XFORM_LO    = 1 + dqtd_pkg::CORDIC_STAGES;
    localparam int DUTY_LO     = XFORM_LO + dqtd_pkg::TRANSFORM_STAGES;

    // configuration registers
    logic [15:0] duty_min_reg;
    logic [15:0] duty_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_min_reg <= 16'd0;
            duty_max_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dqtd_pkg::REG_DUTY_MIN: duty_min_reg <= cfg_data;
                dqtd_pkg::REG_DUTY_MAX: duty_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage takes new data when empty or draining
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stage_en;
    logic [NSTG-1:0] load;

    assign stage_en[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
    assign load[0]          = stage_en[0] && in_valid;

    for (genvar k = 0; k < NSTG - 1; k++)
    begin : g_flow
        assign stage_en[k]   = !valid_reg[k] || stage_en[k+1];
        assign load[k+1]     = stage_en[k+1] && valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NSTG-1];

    // stage 0: quantize the angle to a turn phase and seed the CORDIC
    logic [SINE_TABLE_BITS-1:0] angle_idx;
    logic [31:0]                phase;
    dqtd_pkg::cordic_t          front_next;
    dqtd_pkg::cordic_t          front_reg;

    always_comb
    begin
        angle_idx         = elec_angle[15 -: SINE_TABLE_BITS];
        phase             = {angle_idx, {PHASE_SHIFT{1'b0}}};
        front_next.x      = dqtd_pkg::CORDIC_GAIN;
        front_next.y      = '0;
        front_next.z      = {3'b000, phase[29:0]};
        front_next.quad   = phase[31:30];
        front_next.volt_d = volt_d;
        front_next.volt_q = volt_q;
        front_next.inv    = inv_link_voltage;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            front_reg <= front_next;
        end
    end

    // CORDIC micro-rotation stages
    dqtd_pkg::cordic_t chain [dqtd_pkg::CORDIC_STAGES+1];

    assign chain[0] = front_reg;

    for (genvar i = 0; i < dqtd_pkg::CORDIC_STAGES; i++)
    begin : g_cordic
        dqtd_cordic_stage #(
            .STAGE   (i)
        ) u_stage (
            .clk     (clk),
            .load    (load[i+1]),
            .feed    (chain[i]),
            .rotated (chain[i+1])
        );
    end

    // inverse Park and Clarke
    logic signed [32:0] volt_a;
    logic signed [32:0] volt_b;
    logic signed [32:0] volt_c;
    logic [15:0]        inv;

    dqtd_transform u_transform (
        .clk     (clk),
        .load    (load[XFORM_LO +: dqtd_pkg::TRANSFORM_STAGES]),
        .rotated (chain[dqtd_pkg::CORDIC_STAGES]),
        .volt_a  (volt_a),
        .volt_b  (volt_b),
        .volt_c  (volt_c),
        .inv     (inv)
    );

    // duty scaling and clip
    dqtd_duty u_duty (
        .clk      (clk),
        .load     (load[DUTY_LO +: dqtd_pkg::DUTY_STAGES]),
        .volt_a   (volt_a),
        .volt_b   (volt_b),
        .volt_c   (volt_c),
        .inv      (inv),
        .duty_min (duty_min_reg),
        .duty_max (duty_max_reg),
        .duty_a   (duty_a),
        .duty_b   (duty_b),
        .duty_c   (duty_c)
    );

endmodule
